>>> design/xcc_pkg.sv
// Shared types, constants and round functions for the XChaCha20 cipher.
package xcc_pkg;

   localparam int unsigned RoundCount = 20;
   localparam int unsigned HRoundCount = 20;
   localparam int unsigned RegCount = 8;
   localparam int unsigned AddrWidth = 6;
   localparam int unsigned QueueDepth = 2;

   localparam logic [31:0] Sigma0 = 32'h61707865;
   localparam logic [31:0] Sigma1 = 32'h3320646e;
   localparam logic [31:0] Sigma2 = 32'h79622d32;
   localparam logic [31:0] Sigma3 = 32'h6b206574;

   // Register indexes
   localparam logic [2:0] RegKey0 = 3'd0;
   localparam logic [2:0] RegKey1 = 3'd1;
   localparam logic [2:0] RegKey2 = 3'd2;
   localparam logic [2:0] RegKey3 = 3'd3;
   localparam logic [2:0] RegNonce0 = 3'd4;
   localparam logic [2:0] RegNonce1 = 3'd5;
   localparam logic [2:0] RegNonce2 = 3'd6;
   localparam logic [2:0] RegCounter = 3'd7;

   typedef logic [31:0] word_type;
   typedef word_type [15:0] block_type;

   // One classified item between front and back
   typedef struct packed {
      logic [31:0] data;
      logic [2:0]  count;
      logic        last;
      logic        derive;  // subkey must be derived first
      logic        fresh;   // a new keystream block is needed
      logic [3:0]  pos;
   } item_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_HROUND,
      ST_KROUND,
      ST_ADD,
      ST_OUT
   } back_state_type;

   function automatic word_type rotl(input word_type v, input int unsigned n);
      rotl = (v << n) | (v >> (32 - n));
   endfunction

   function automatic logic [127:0] qround(input word_type a, input word_type b,
                                          input word_type c, input word_type d);
      word_type ta, tb, tc, td;
      ta = a; tb = b; tc = c; td = d;
      ta = ta + tb; td = rotl(td ^ ta, 16);
      tc = tc + td; tb = rotl(tb ^ tc, 12);
      ta = ta + tb; td = rotl(td ^ ta, 8);
      tc = tc + td; tb = rotl(tb ^ tc, 7);
      qround = {td, tc, tb, ta};
   endfunction

   // One column or diagonal round
   function automatic block_type do_round(input block_type s, input logic diag);
      block_type r;
      logic [127:0] q;
      r = s;
      if (!diag) begin
         for (int i = 0; i < 4; i++) begin
            q = qround(s[i], s[4+i], s[8+i], s[12+i]);
            {r[12+i], r[8+i], r[4+i], r[i]} = q;
         end
      end else begin
         q = qround(s[0], s[5], s[10], s[15]);
         {r[15], r[10], r[5], r[0]} = q;
         q = qround(s[1], s[6], s[11], s[12]);
         {r[12], r[11], r[6], r[1]} = q;
         q = qround(s[2], s[7], s[8], s[13]);
         {r[13], r[8], r[7], r[2]} = q;
         q = qround(s[3], s[4], s[9], s[14]);
         {r[14], r[9], r[4], r[3]} = q;
      end
      do_round = r;
   endfunction

endpackage

>>> design/xcc_front.sv
// Front end: accepts input words and tags them with subkey and block needs.
module xcc_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              cfg_write,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [31:0]       req_data_in,
   input  logic [2:0]        req_byte_count,
   input  logic              req_last_in,
   output logic              push,
   output xcc_pkg::item_type push_item,
   input  logic              queue_full
);
   import xcc_pkg::*;

   logic       subkey_ok_ff, subkey_ok_in;
   logic [3:0] pos_ff, pos_in;

   assign req_ready = !queue_full;
   assign push = req_valid && req_ready;

   // Classify the word
   always_comb begin
      push_item.data = req_data_in;
      push_item.count = req_byte_count;
      push_item.last = req_last_in;
      push_item.derive = !subkey_ok_ff;
      push_item.fresh = (pos_ff == 4'd0);
      push_item.pos = pos_ff;
   end

   // Track word position and subkey status
   always_comb begin
      subkey_ok_in = subkey_ok_ff;
      pos_in = pos_ff;
      if (cfg_write) begin
         subkey_ok_in = 1'b0;
         pos_in = 4'd0;
      end else if (push) begin
         subkey_ok_in = 1'b1;
         if (req_last_in || pos_ff == 4'd15) pos_in = 4'd0;
         else pos_in = pos_ff + 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         subkey_ok_ff <= 1'b0;
         pos_ff <= 4'd0;
      end else begin
         subkey_ok_ff <= subkey_ok_in;
         pos_ff <= pos_in;
      end
   end
endmodule

>>> design/xcc_queue.sv
// Short queue of classified items between front and back.
module xcc_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  xcc_pkg::item_type push_item,
   output logic              full,
   output logic              nonempty,
   input  logic              pop,
   output xcc_pkg::item_type head
);
   import xcc_pkg::*;

   item_type   slot_ff [QueueDepth];
   logic       wptr_ff, wptr_in, rptr_ff, rptr_in;
   logic [1:0] cnt_ff, cnt_in;

   assign full = (cnt_ff == 2'(QueueDepth));
   assign nonempty = (cnt_ff != 2'd0);
   assign head = slot_ff[rptr_ff];

   always_comb begin
      wptr_in = push ? !wptr_ff : wptr_ff;
      rptr_in = pop ? !rptr_ff : rptr_ff;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (push) slot_ff[wptr_ff] <= push_item;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= 1'b0;
         rptr_ff <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         cnt_ff <= cnt_in;
      end
   end
endmodule

>>> design/xcc_back.sv
// Back end: derives the subkey, makes keystream blocks and XORs data.
module xcc_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              cfg_write,
   input  logic [63:0]       key0,
   input  logic [63:0]       key1,
   input  logic [63:0]       key2,
   input  logic [63:0]       key3,
   input  logic [63:0]       nonce0,
   input  logic [63:0]       nonce1,
   input  logic [63:0]       nonce2,
   input  logic [63:0]       counter_start,
   input  logic              nonempty,
   input  xcc_pkg::item_type head,
   output logic              pop,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [31:0]       rsp_data_out,
   output logic [2:0]        rsp_byte_count_out,
   output logic              rsp_last_out
);
   import xcc_pkg::*;

   back_state_type state_ff, state_in;
   block_type      work_ff, work_in;
   block_type      ks_ff, ks_in;
   word_type [7:0] subkey_ff, subkey_in;
   logic [63:0]    ctr_ff, ctr_in;
   logic [4:0]     rnd_ff, rnd_in;
   logic [31:0]    data_ff, data_in;
   logic [2:0]     count_ff, count_in;
   logic           last_ff, last_in;
   logic           busy;
   block_type      hinit, kinit, rounded;
   word_type       ksword, mask;

   assign busy = rsp_valid && !rsp_ready;

   always_comb begin
      hinit = '{default: '0};
      hinit[0] = Sigma0; hinit[1] = Sigma1; hinit[2] = Sigma2; hinit[3] = Sigma3;
      hinit[4] = key0[31:0]; hinit[5] = key0[63:32];
      hinit[6] = key1[31:0]; hinit[7] = key1[63:32];
      hinit[8] = key2[31:0]; hinit[9] = key2[63:32];
      hinit[10] = key3[31:0]; hinit[11] = key3[63:32];
      hinit[12] = nonce0[31:0]; hinit[13] = nonce0[63:32];
      hinit[14] = nonce1[31:0]; hinit[15] = nonce1[63:32];
      kinit = '{default: '0};
      kinit[0] = Sigma0; kinit[1] = Sigma1; kinit[2] = Sigma2; kinit[3] = Sigma3;
      for (int i = 0; i < 8; i++) kinit[4+i] = subkey_ff[i];
      kinit[12] = ctr_ff[31:0]; kinit[13] = ctr_ff[63:32];
      kinit[14] = nonce2[31:0]; kinit[15] = nonce2[63:32];
      rounded = do_round(work_ff, rnd_ff[0]);
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (nonempty && !busy) begin
               if (head.derive) state_in = ST_HROUND;
               else if (head.fresh) state_in = ST_KROUND;
               else state_in = ST_OUT;
            end
         end
         ST_HROUND: if (rnd_ff == 5'(HRoundCount - 1)) state_in = ST_KROUND;
         ST_KROUND: if (rnd_ff == 5'(RoundCount - 1)) state_in = ST_ADD;
         ST_ADD:    state_in = ST_OUT;
         ST_OUT:    state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // Datapath and outputs
   always_comb begin
      work_in = work_ff;
      ks_in = ks_ff;
      subkey_in = subkey_ff;
      ctr_in = ctr_ff;
      rnd_in = rnd_ff;
      data_in = data_ff;
      count_in = count_ff;
      last_in = last_ff;
      pop = 1'b0;
      ksword = ks_ff[head.pos];
      unique case (head.count)
         3'd0: mask = 32'h0;
         3'd1: mask = 32'h0000_00ff;
         3'd2: mask = 32'h0000_ffff;
         3'd3: mask = 32'h00ff_ffff;
         default: mask = 32'hffff_ffff;
      endcase
      unique case (state_ff)
         ST_IDLE: begin
            rnd_in = 5'd0;
            if (nonempty && !busy) begin
               if (head.derive) work_in = hinit;
               else if (head.fresh) work_in = kinit;
            end
         end
         ST_HROUND: begin
            rnd_in = rnd_ff + 5'd1;
            work_in = rounded;
            if (rnd_ff == 5'(HRoundCount - 1)) begin
               for (int i = 0; i < 4; i++) begin
                  subkey_in[i] = rounded[i];
                  subkey_in[4+i] = rounded[12+i];
               end
               rnd_in = 5'd0;
               work_in = kinit;
               work_in[4] = rounded[0]; work_in[5] = rounded[1];
               work_in[6] = rounded[2]; work_in[7] = rounded[3];
               work_in[8] = rounded[12]; work_in[9] = rounded[13];
               work_in[10] = rounded[14]; work_in[11] = rounded[15];
            end
         end
         ST_KROUND: begin
            rnd_in = rnd_ff + 5'd1;
            work_in = rounded;
         end
         ST_ADD: begin
            for (int i = 0; i < 16; i++) ks_in[i] = work_ff[i] + kinit[i];
         end
         ST_OUT: begin
            pop = 1'b1;
            data_in = (head.data ^ ksword) & mask;
            count_in = head.count;
            last_in = head.last;
            if (head.last || head.pos == 4'd15) ctr_in = ctr_ff + 64'd1;
         end
         default: ;
      endcase
      if (cfg_write) ctr_in = counter_start;
   end

   always_ff @(posedge clock) begin
      work_ff <= work_in;
      ks_ff <= ks_in;
      subkey_ff <= subkey_in;
      data_ff <= data_in;
      count_ff <= count_in;
      last_ff <= last_in;
      rnd_ff <= rnd_in;
   end

   // Hold the result until the transfer completes
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ctr_ff <= '0;
         rsp_valid <= 1'b0;
      end else begin
         state_ff <= state_in;
         ctr_ff <= ctr_in;
         if (pop) rsp_valid <= 1'b1;
         else if (rsp_ready) rsp_valid <= 1'b0;
      end
   end

   assign rsp_data_out = data_ff;
   assign rsp_byte_count_out = count_ff;
   assign rsp_last_out = last_ff;
endmodule

>>> design/xchacha20_stream_cipher.sv
// Top level of the XChaCha20 stream cipher.
// One 32-bit word goes in and one comes out per transfer. The back end runs
// one ChaCha round per cycle: a word that opens a 64-byte block goes through
// 20 rounds, the final add and the output step, other words go straight to
// the output step, and the first word after a register write first derives
// the HChaCha20 subkey. A two-entry queue separates input acceptance from the
// round unit. Registers are 64 bits at byte address 8*i.
module xchacha20_stream_cipher (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_data_in,
   input  logic [2:0]  req_byte_count,
   input  logic        req_last_in,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_data_out,
   output logic [2:0]  rsp_byte_count_out,
   output logic        rsp_last_out,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [xcc_pkg::AddrWidth-1:0] paddr,
   input  logic [63:0] pwdata,
   output logic [63:0] prdata,
   output logic        pready
);
   import xcc_pkg::*;

   logic [63:0] regs_ff [RegCount];
   logic        wr, valid_addr, push, full, nonempty, pop;
   logic [2:0]  idx;
   logic [63:0] ctr_load;
   item_type    push_item, head;

   assign pready = 1'b1;
   assign idx = paddr[5:3];
   assign valid_addr = (paddr[2:0] == 3'd0);
   assign wr = psel && penable && pwrite && valid_addr;
   assign prdata = regs_ff[idx];

   // Reload the counter with the value that holds after this write
   assign ctr_load = (idx == RegCounter) ? pwdata : regs_ff[RegCounter];

   // Register file
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < RegCount; i++) regs_ff[i] <= '0;
      end else if (wr) begin
         regs_ff[idx] <= pwdata;
      end
   end

   xcc_front u_front (
      .clock, .reset, .cfg_write(wr), .req_valid, .req_ready,
      .req_data_in, .req_byte_count, .req_last_in,
      .push, .push_item, .queue_full(full)
   );

   xcc_queue u_queue (
      .clock, .reset, .push, .push_item, .full, .nonempty, .pop, .head
   );

   xcc_back u_back (
      .clock, .reset, .cfg_write(wr),
      .key0(regs_ff[RegKey0]), .key1(regs_ff[RegKey1]),
      .key2(regs_ff[RegKey2]), .key3(regs_ff[RegKey3]),
      .nonce0(regs_ff[RegNonce0]), .nonce1(regs_ff[RegNonce1]),
      .nonce2(regs_ff[RegNonce2]), .counter_start(ctr_load),
      .nonempty, .head, .pop,
      .rsp_valid, .rsp_ready, .rsp_data_out, .rsp_byte_count_out, .rsp_last_out
   );
endmodule

>>> verif/xcc_checker.sv
// Checker for the XChaCha20 cipher: watches transfers, predicts words and compares them.
module xcc_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [31:0] req_data_in,
   input  logic [2:0]  req_byte_count,
   input  logic        req_last_in,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [31:0] rsp_data_out,
   input  logic [2:0]  rsp_byte_count_out,
   input  logic        rsp_last_out,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [xcc_pkg::AddrWidth-1:0] paddr,
   input  logic [63:0] pwdata,
   input  logic        pready,
   output int          mismatches,
   output int          pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef logic [31:0] chacha_state_type [16];

   typedef struct {
      logic [31:0] data;
      logic [2:0]  count;
      logic        last;
   } cipher_word_type;

   cipher_word_type expected_words[$];

   // Predicted cipher state
   logic [63:0] cfg_regs [xcc_pkg::RegCount];
   logic [31:0] subkey [8];
   logic        subkey_valid;
   logic [63:0] block_ctr;
   logic [3:0]  word_pos;
   logic [31:0] keystream [16];

   function automatic logic [31:0] rot_left(logic [31:0] v, int n);
      return (v << n) | (v >> (32 - n));
   endfunction

   function automatic chacha_state_type quarter(chacha_state_type s, int a, int b, int c, int d);
      s[a] += s[b]; s[d] = rot_left(s[d] ^ s[a], 16);
      s[c] += s[d]; s[b] = rot_left(s[b] ^ s[c], 12);
      s[a] += s[b]; s[d] = rot_left(s[d] ^ s[a], 8);
      s[c] += s[d]; s[b] = rot_left(s[b] ^ s[c], 7);
      return s;
   endfunction

   // Alternate column and diagonal rounds, column first
   function automatic chacha_state_type permute(chacha_state_type s, int rounds);
      for (int r = 0; r < rounds; r++) begin
         if (r % 2 == 0) begin
            s = quarter(s, 0, 4, 8, 12);
            s = quarter(s, 1, 5, 9, 13);
            s = quarter(s, 2, 6, 10, 14);
            s = quarter(s, 3, 7, 11, 15);
         end else begin
            s = quarter(s, 0, 5, 10, 15);
            s = quarter(s, 1, 6, 11, 12);
            s = quarter(s, 2, 7, 8, 13);
            s = quarter(s, 3, 4, 9, 14);
         end
      end
      return s;
   endfunction

   function automatic chacha_state_type sigma_state();
      chacha_state_type s;
      foreach (s[i]) s[i] = '0;
      s[0] = xcc_pkg::Sigma0;
      s[1] = xcc_pkg::Sigma1;
      s[2] = xcc_pkg::Sigma2;
      s[3] = xcc_pkg::Sigma3;
      return s;
   endfunction

   // Derive subkey if needed, refill keystream at block start, then advance position
   task automatic encrypt_word(input logic [31:0] data, input logic [2:0] count,
                               input logic last, output cipher_word_type res);
      chacha_state_type s, init;
      logic [31:0] mask;
      if (!subkey_valid) begin
         s = sigma_state();
         for (int i = 0; i < 4; i++) begin
            s[4 + 2*i] = cfg_regs[i][31:0];
            s[5 + 2*i] = cfg_regs[i][63:32];
         end
         s[12] = cfg_regs[xcc_pkg::RegNonce0][31:0];
         s[13] = cfg_regs[xcc_pkg::RegNonce0][63:32];
         s[14] = cfg_regs[xcc_pkg::RegNonce1][31:0];
         s[15] = cfg_regs[xcc_pkg::RegNonce1][63:32];
         s = permute(s, xcc_pkg::HRoundCount);
         for (int i = 0; i < 4; i++) begin
            subkey[i] = s[i];
            subkey[4 + i] = s[12 + i];
         end
         subkey_valid = 1'b1;
      end
      if (word_pos == 0) begin
         init = sigma_state();
         for (int i = 0; i < 8; i++) init[4 + i] = subkey[i];
         init[12] = block_ctr[31:0];
         init[13] = block_ctr[63:32];
         init[14] = cfg_regs[xcc_pkg::RegNonce2][31:0];
         init[15] = cfg_regs[xcc_pkg::RegNonce2][63:32];
         s = permute(init, xcc_pkg::RoundCount);
         for (int i = 0; i < 16; i++) keystream[i] = s[i] + init[i];
      end
      mask = (count >= 4) ? 32'hffff_ffff : (32'h1 << (8 * count)) - 32'h1;
      res.data = (data ^ keystream[word_pos]) & mask;
      res.count = count;
      res.last = last;
      if (last || word_pos == 4'd15) begin
         block_ctr = block_ctr + 64'd1;
         word_pos = '0;
      end else begin
         word_pos = word_pos + 4'd1;
      end
   endtask

   always @(posedge clock) begin
      cipher_word_type res;
      cipher_word_type want;
      if (reset) begin
         foreach (cfg_regs[i]) cfg_regs[i] = '0;
         subkey_valid = 1'b0;
         block_ctr = '0;
         word_pos = '0;
         mismatches = 0;
         expected_words.delete();
      end else begin
         // Track register writes
         if (psel && penable && pwrite && pready) begin
            cfg_regs[paddr[5:3]] = pwdata;
            subkey_valid = 1'b0;
            block_ctr = cfg_regs[xcc_pkg::RegCounter];
            word_pos = '0;
         end
         // Predict each input transfer
         if (req_valid && req_ready) begin
            encrypt_word(req_data_in, req_byte_count, req_last_in, res);
            expected_words.push_back(res);
         end
         // Compare each output transfer
         if (rsp_valid && rsp_ready) begin
            if (expected_words.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected output word %h count %0d last %0b",
                           rsp_data_out, rsp_byte_count_out, rsp_last_out);
            end else begin
               want = expected_words.pop_front();
               if (want.data !== rsp_data_out || want.count !== rsp_byte_count_out ||
                   want.last !== rsp_last_out) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: want data %h count %0d last %0b, got %h %0d %0b",
                              want.data, want.count, want.last,
                              rsp_data_out, rsp_byte_count_out, rsp_last_out);
               end
            end
         end
      end
      pending = expected_words.size();
   end

endmodule

>>> verif/tb.sv
// Testbench top for the XChaCha20 cipher: stimulus, register phases and verdict.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CycleLimit = 400000;
   localparam int DrainCycles = 60;

   typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [31:0] req_data_in = '0;
   logic [2:0]  req_byte_count = 3'd4;
   logic        req_last_in = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [31:0] rsp_data_out;
   logic [2:0]  rsp_byte_count_out;
   logic        rsp_last_out;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [xcc_pkg::AddrWidth-1:0] paddr = '0;
   logic [63:0] pwdata = '0;
   logic [63:0] prdata;
   logic        pready;

   int            mismatches;
   int            pending;
   int            cycles = 0;
   idle_mode_type idle_mode = IDLE_NONE;
   logic [63:0]   reg_values [xcc_pkg::RegCount];

   xchacha20_stream_cipher dut (.*);

   xcc_checker u_checker (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CycleLimit) begin
         $display("[xchacha20_stream_cipher] ERROR");
         $finish;
      end
   end

   // Receiver stalls by phase
   always @(posedge clock) begin
      case (idle_mode)
         IDLE_RECEIVER: rsp_ready <= ($urandom_range(99) >= 54);
         IDLE_BOTH:     rsp_ready <= ($urandom_range(99) >= 8);
         default:       rsp_ready <= 1'b1;
      endcase
   end

   function automatic bit sender_idles();
      case (idle_mode)
         IDLE_SENDER: return $urandom_range(99) < 54;
         IDLE_BOTH:   return $urandom_range(99) < 8;
         default:     return 1'b0;
      endcase
   endfunction

   // Hold valid with the payload until the transfer completes
   task automatic send_word(input logic [31:0] data, input logic [2:0] count,
                            input logic last);
      while (sender_idles()) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data_in <= data;
      req_byte_count <= count;
      req_last_in <= last;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // Drop valid and hold until every predicted word has arrived
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   // Program all registers through the setup and access cycles
   task automatic write_regs();
      for (int i = 0; i < xcc_pkg::RegCount; i++) begin
         @(posedge clock);
         psel <= 1'b1;
         penable <= 1'b0;
         pwrite <= 1'b1;
         paddr <= xcc_pkg::AddrWidth'(8 * i);
         pwdata <= reg_values[i];
         @(posedge clock);
         penable <= 1'b1;
         @(posedge clock);
         psel <= 1'b0;
         penable <= 1'b0;
         pwrite <= 1'b0;
      end
   endtask

   // Messages of random length; mostly full words, final word of 1 to 4 bytes, some noise
   task automatic send_messages(input int words);
      int sent = 0;
      int len;
      logic [2:0] count;
      while (sent < words) begin
         len = ($urandom_range(3) == 0) ? $urandom_range(40) + 1 : $urandom_range(18) + 1;
         for (int w = 0; w < len && sent < words; w++) begin
            count = 3'd4;
            if (w == len - 1) count = 3'($urandom_range(4, 1));
            if ($urandom_range(19) == 0) count = 3'($urandom_range(7));
            send_word($urandom, count, (w == len - 1) || ($urandom_range(49) == 0));
            sent++;
         end
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Reset configuration, directed field extremes
      idle_mode = IDLE_NONE;
      for (int c = 0; c < 8; c++) send_word(32'h0000_0000, 3'(c), 1'b0);
      for (int c = 0; c < 8; c++) send_word(32'hffff_ffff, 3'(c), c == 7);
      send_word(32'h1234_5678, 3'd4, 1'b1);
      send_word(32'h8000_0001, 3'd2, 1'b1);
      drain();

      // All ones, counter at its maximum to wrap
      foreach (reg_values[i]) reg_values[i] = 64'hffff_ffff_ffff_ffff;
      write_regs();
      idle_mode = IDLE_RECEIVER;
      for (int w = 0; w < 20; w++) send_word($urandom, 3'd4, w == 19);
      send_word($urandom, 3'd3, 1'b1);
      drain();

      // Counter low word at its maximum to carry into the high word
      foreach (reg_values[i]) reg_values[i] = {$urandom, $urandom};
      reg_values[xcc_pkg::RegCounter] = 64'h0000_0000_ffff_ffff;
      write_regs();
      idle_mode = IDLE_SENDER;
      send_messages(40);
      drain();
      send_messages(40);
      drain();

      // Random settings, all zeros in the last phase, through the idling phases
      for (int p = 0; p < 4; p++) begin
         foreach (reg_values[i]) reg_values[i] = {$urandom, $urandom};
         if (p == 3) foreach (reg_values[i]) reg_values[i] = '0;
         write_regs();
         idle_mode = idle_mode_type'(p);
         send_messages(45);
         if (p == 1) drain();
         send_messages(45);
         drain();
      end

      if (mismatches == 0) begin
         $display("[xchacha20_stream_cipher] OK");
      end else begin
         $display("[xchacha20_stream_cipher] ERROR");
      end
      $finish;
   end

endmodule

>>> files.f
design/xcc_pkg.sv
design/xcc_front.sv
design/xcc_queue.sv
design/xcc_back.sv
design/xchacha20_stream_cipher.sv
verif/xcc_checker.sv
verif/tb.sv
